[design/local_alignment_scorer_top_macros.svh]
// Assertion macros for the local alignment scorer checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef LOCAL_ALIGNMENT_SCORER_TOP_MACROS_SVH
`define LOCAL_ALIGNMENT_SCORER_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define LAS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define LAS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/las_pkg.sv]
// Shared types and constants for the local alignment scorer.
// No dependencies; imported by the cell, the top level and the checker.
package las_pkg;

  localparam int QUERY_MAX = 64;
  localparam int IDX_W     = $clog2(QUERY_MAX);
  localparam int POS_W     = $clog2(QUERY_MAX + 1);
  localparam int SYM_W     = 8;
  localparam int SCORE_W   = 10;
  localparam int MATCH_W   = 4;
  localparam int PEN_W     = 5;
  localparam int SUM_W     = SCORE_W + 2;
  localparam int CELL_MAX  = (1 << SCORE_W) - 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = CFG_IDX_W'(2);

  localparam logic [MATCH_W-1:0] MATCH_RESET    = MATCH_W'(3);
  localparam logic [PEN_W-1:0]   MISMATCH_RESET = 5'b11111;
  localparam logic [PEN_W-1:0]   GAP_RESET      = 5'b11110;

  typedef struct packed {
    logic [MATCH_W-1:0] eq_score;
    logic [PEN_W-1:0]   ne_score;
    logic [PEN_W-1:0]   gap_score;
  } cfg_t;

  // one transaction travelling along the row of cells
  typedef struct packed {
    logic               valid;
    logic               is_target;
    logic               last;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [POS_W-1:0]   len;
    logic [SYM_W-1:0]   sym;
    logic [SCORE_W-1:0] above;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] maxv;
  } token_t;

endpackage

[design/local_alignment_scorer_top.sv]
// Local alignment scorer top: config registers, load counter, row of QUERY_MAX cells.
// A last target transaction, once accepted, passes through the head register and the row of
// cells; the strobe is registered from the token that leaves the last cell.
// Throughput: one transaction per cycle; each moves one cell down the row per cycle.
// busy stays low. Synchronous reset restores score registers, clears column and best.
// Depends on las_pkg and las_cell.
module local_alignment_scorer_top
  import las_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [SYM_W-1:0]     symbol,
  input  logic                 last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 result_valid,
  output logic [SCORE_W-1:0]   best_score
);

  cfg_t               cfg;
  logic [POS_W-1:0]   load_pos;
  logic [POS_W-1:0]   load_pos_next;
  logic [POS_W-1:0]   pos_inc;
  logic               wr_en;
  logic               accept;
  logic [SCORE_W-1:0] running_best;
  logic [SCORE_W-1:0] best_next;
  token_t             tok_head;
  token_t             tok [QUERY_MAX+1];
  token_t             tok_exit;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eq_score  <= MATCH_RESET;
      cfg.ne_score  <= MISMATCH_RESET;
      cfg.gap_score <= GAP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MATCH:    cfg.eq_score  <= cfg_data[MATCH_W-1:0];
        REG_MISMATCH: cfg.ne_score  <= cfg_data[PEN_W-1:0];
        REG_GAP:      cfg.gap_score <= cfg_data[PEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    wr_en         = (load_pos < POS_W'(QUERY_MAX));
    pos_inc       = wr_en ? load_pos + POS_W'(1) : load_pos;
    load_pos_next = load_pos;
    if (accept && !req_type) begin
      load_pos_next = last ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos       <= '0;
      tok_head.valid <= 1'b0;
    end else begin
      load_pos           <= load_pos_next;
      tok_head.valid     <= accept;
      tok_head.is_target <= req_type;
      tok_head.last      <= last;
      tok_head.wr_en     <= wr_en;
      tok_head.wr_idx    <= load_pos[IDX_W-1:0];
      tok_head.len       <= pos_inc;
      tok_head.sym       <= symbol;
      tok_head.above     <= '0;
      tok_head.diag      <= '0;
      tok_head.maxv      <= '0;
    end
  end

  assign tok[0] = tok_head;

  for (genvar k = 0; k < QUERY_MAX; k++) begin : g_row
    las_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(k)),
      .cfg      (cfg),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  assign tok_exit  = tok[QUERY_MAX];
  assign best_next = (tok_exit.maxv > running_best) ? tok_exit.maxv : running_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      running_best <= '0;
    end else begin
      result_valid <= 1'b0;
      if (tok_exit.valid) begin
        if (tok_exit.is_target) begin
          if (tok_exit.last) begin
            result_valid <= 1'b1;
            running_best <= '0;
          end else begin
            running_best <= best_next;
          end
        end else if (tok_exit.last) begin
          running_best <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_exit.valid && tok_exit.is_target && tok_exit.last) begin
      best_score <= best_next;
    end
  end

endmodule

[design/las_cell.sv]
// One query position of the scoring row: holds its symbol, score and active flag.
// Depends on las_pkg.
module las_cell
  import las_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  cfg_t             cfg,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic [SYM_W-1:0]          qsym;
  logic [SCORE_W-1:0]        score;
  logic                      active;
  logic                      hit;
  logic                      is_load;
  logic signed [SUM_W-1:0]   sub;
  logic signed [SUM_W-1:0]   gap;
  logic signed [SUM_W-1:0]   d_sum;
  logic signed [SUM_W-1:0]   u_sum;
  logic signed [SUM_W-1:0]   l_sum;
  logic signed [SUM_W-1:0]   best;
  logic [SCORE_W-1:0]        cell_val;
  token_t                    tok_next;

  assign hit     = tok_in.valid && tok_in.is_target && active;
  assign is_load = tok_in.valid && !tok_in.is_target;

  always_comb begin
    if (qsym == tok_in.sym) begin
      sub = $signed({{(SUM_W-MATCH_W){1'b0}}, cfg.eq_score});
    end else begin
      sub = $signed({{(SUM_W-PEN_W){cfg.ne_score[PEN_W-1]}}, cfg.ne_score});
    end
    gap   = $signed({{(SUM_W-PEN_W){cfg.gap_score[PEN_W-1]}}, cfg.gap_score});
    d_sum = $signed({2'b00, tok_in.diag}) + sub;
    u_sum = $signed({2'b00, tok_in.above}) + gap;
    l_sum = $signed({2'b00, score}) + gap;
    best  = '0;
    if (d_sum > best) best = d_sum;
    if (u_sum > best) best = u_sum;
    if (l_sum > best) best = l_sum;
    if (best > $signed(SUM_W'(CELL_MAX))) begin
      cell_val = SCORE_W'(CELL_MAX);
    end else begin
      cell_val = best[SCORE_W-1:0];
    end
    tok_next = tok_in;
    if (hit) begin
      tok_next.above = cell_val;
      tok_next.diag  = score;
      if (cell_val > tok_in.maxv) tok_next.maxv = cell_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      active        <= 1'b0;
      score         <= '0;
    end else begin
      tok_out <= tok_next;
      if (is_load && tok_in.last) begin
        active <= ({1'b0, cell_idx} < tok_in.len);
        score  <= '0;
      end else if (hit) begin
        score <= tok_in.last ? '0 : cell_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_load && tok_in.wr_en && (tok_in.wr_idx == cell_idx)) begin
      qsym <= tok_in.sym;
    end
  end

endmodule

[design/las_checker.sv]
// Port-level checker for local_alignment_scorer_top, bound to the top level.
// Depends on las_pkg and local_alignment_scorer_top_macros.svh.
`include "local_alignment_scorer_top_macros.svh"

module las_checker
  import las_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               last,
  input logic               result_valid,
  input logic [SCORE_W-1:0] best_score
);

  localparam int LAT = QUERY_MAX + 2;

  logic tgt_end;

  assign tgt_end = start && !busy && req_type && last;

  `LAS_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `LAS_ASSERT_SAME(a_quiet_after_rst, $past(rst), !result_valid, "result right after reset")
  `LAS_ASSERT_SAME(a_result_cause, result_valid, $past(tgt_end, LAT), "orphan result")
  `LAS_ASSERT_SAME(a_score_known, result_valid, !$isunknown(best_score), "unknown score")

endmodule

bind local_alignment_scorer_top las_checker u_las_checker (.*);
